@@ hw/rtl/dswd_pkg.sv @@
// Shared constants for the delay slot wheel: field widths, default sizes,
// operation and status codes. No dependencies.
package dswd_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_SLOTS     = 16;
    localparam int DEF_SLOT_CAPACITY = 64;
    localparam int DEF_WORLD_HEIGHT  = 256;

    // Port field widths
    localparam int OP_W     = 2;
    localparam int X_W      = 4;
    localparam int Y_IN_W   = 10;
    localparam int Z_W      = 4;
    localparam int OUT_Y_W  = 8;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 11;
    localparam int TD_W     = 5;

    // Delay register value after reset
    localparam int TD_RESET = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FLUID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

@@ hw/rtl/dswd_slot_mem.sv @@
// Coordinate store of the wheel: one write port, one read port with
// registered read data. Depends on nothing.
module dswd_slot_mem #(
    parameter int AW = 10,
    parameter int EW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [EW-1:0] rdata
);

    localparam int DEPTH = 1 << AW;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dswd_fill_regs.sv @@
// Per-slot fill counts, cleared by reset; one read and one write port.
// Depends on nothing.
module dswd_fill_regs #(
    parameter int NUM_SLOTS = 16,
    parameter int SW        = 4,
    parameter int FW        = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [SW-1:0] rd_slot,
    output logic [FW-1:0] rd_fill,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_slot,
    input  logic [FW-1:0] wr_fill
);

    logic [FW-1:0] fill_reg [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            fill_reg[wr_slot] <= wr_fill;
        end
    end

    assign rd_fill = fill_reg[rd_slot];

endmodule

@@ hw/rtl/delay_slot_wheel_dedup_top.sv @@
// Top level of the delay slot wheel scheduler: control sequencer, slot
// pointers and counters. Uses dswd_pkg, dswd_slot_mem and dswd_fill_regs.
//
// Usage:
//   Requests enter on start/operation/rel_x/pos_y/rel_z/is_fluid and are taken
//   at a clock edge with start high and busy low. Results leave on
//   out_x/out_y/out_z/coord_valid/last/status/total_queued, each valid for
//   exactly one cycle while done is high; last marks the final result of a
//   request. The receiver cannot stall the block; it must take every result.
//   cfg_we/cfg_data write the tick delay (number of wheel slots); write it
//   only while busy is low and no result is pending.
// Latency and throughput:
//   Tick, unused codes and rejected adds (height, fluid): result in the cycle
//   after the request, busy stays low, so one request per cycle.
//   Add: reads the stored cells of the add slot in order, one per cycle, and
//   answers at the first duplicate; else (or at once if empty) it appends.
//   Drain of n cells: n results, one per cycle, in stored order; an empty
//   drain answers in the next cycle.
// Reset:
//   Clears all fill counts (no clearing pass over the store), the cell total,
//   the simulate slot, and sets the add slot to the reset delay minus one.
module delay_slot_wheel_dedup_top #(
    parameter int MAX_SLOTS     = dswd_pkg::DEF_MAX_SLOTS,
    parameter int SLOT_CAPACITY = dswd_pkg::DEF_SLOT_CAPACITY,
    parameter int WORLD_HEIGHT  = dswd_pkg::DEF_WORLD_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dswd_pkg::OP_W-1:0]           operation,
    input  logic [dswd_pkg::X_W-1:0]            rel_x,
    input  logic signed [dswd_pkg::Y_IN_W-1:0]  pos_y,
    input  logic [dswd_pkg::Z_W-1:0]            rel_z,
    input  logic                                is_fluid,
    input  logic                                cfg_we,
    input  logic [dswd_pkg::TD_W-1:0]           cfg_data,
    output logic                                done,
    output logic [dswd_pkg::X_W-1:0]            out_x,
    output logic [dswd_pkg::OUT_Y_W-1:0]        out_y,
    output logic [dswd_pkg::Z_W-1:0]            out_z,
    output logic                                coord_valid,
    output logic                                last,
    output logic [dswd_pkg::STATUS_W-1:0]       status,
    output logic [dswd_pkg::TOTAL_W-1:0]        total_queued
);

    import dswd_pkg::*;

    // Derived sizes
    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW    = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int FW    = $clog2(SLOT_CAPACITY + 1);
    localparam int YW    = $clog2(WORLD_HEIGHT);
    localparam int EW    = X_W + YW + Z_W;
    localparam int AW    = SW + IW;
    localparam int TW    = $clog2(MAX_SLOTS * SLOT_CAPACITY + 1);
    localparam int EFF_W = 7;
    localparam int RST_EFF = (TD_RESET > MAX_SLOTS) ? MAX_SLOTS : TD_RESET;

    localparam logic [SW-1:0]     ADD_SLOT_RST = SW'(RST_EFF - 1);
    localparam logic [FW-1:0]     CAP_L        = FW'(SLOT_CAPACITY);
    localparam logic [Y_IN_W-1:0] HEIGHT_L     = Y_IN_W'(WORLD_HEIGHT);
    localparam logic [EFF_W-1:0]  MAX_SLOTS_L  = EFF_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DRAIN
    } state_t;

    // Control state
    state_t          state_reg,     state_next;
    logic [TD_W-1:0] td_reg,        td_next;
    logic [SW-1:0]   add_slot_reg,  add_slot_next;
    logic [SW-1:0]   sim_slot_reg,  sim_slot_next;
    logic [TW-1:0]   total_reg,     total_next;
    logic [SW-1:0]   slot_reg,      slot_next;
    logic [FW-1:0]   n_reg,         n_next;
    logic [FW-1:0]   cnt_reg,       cnt_next;
    logic            rvld_reg,      rvld_next;
    logic            rlast_reg,     rlast_next;

    // Held request coordinate
    logic [X_W-1:0]  x_reg,         x_next;
    logic [YW-1:0]   y_reg,         y_next;
    logic [Z_W-1:0]  z_reg,         z_next;

    // Registered result
    logic                done_reg,   done_next;
    logic [X_W-1:0]      ox_reg,     ox_next;
    logic [OUT_Y_W-1:0]  oy_reg,     oy_next;
    logic [Z_W-1:0]      oz_reg,     oz_next;
    logic                cv_reg,     cv_next;
    logic                last_reg,   last_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Store and fill-count ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic [SW-1:0] fill_rd_slot;
    logic [FW-1:0] fill_rd;
    logic          fill_we;
    logic [SW-1:0] fill_wr_slot;
    logic [FW-1:0] fill_wr;

    // Helpers
    logic [EFF_W-1:0] eff_delay;
    logic [EFF_W-1:0] sim_inc;
    logic             outside;
    logic             match;
    logic [8:0]       rd_y9;
    logic [31:0]      total32;

    dswd_slot_mem #(
        .AW (AW),
        .EW (EW)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dswd_fill_regs #(
        .NUM_SLOTS (MAX_SLOTS),
        .SW        (SW),
        .FW        (FW)
    ) u_fill_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (fill_rd_slot),
        .rd_fill (fill_rd),
        .wr_en   (fill_we),
        .wr_slot (fill_wr_slot),
        .wr_fill (fill_wr)
    );

    // Effective wheel size: zero acts as one, clamp to the slot count
    always_comb
    begin
        if (td_reg == '0)
        begin
            eff_delay = EFF_W'(1);
        end
        else if (EFF_W'(td_reg) > MAX_SLOTS_L)
        begin
            eff_delay = MAX_SLOTS_L;
        end
        else
        begin
            eff_delay = EFF_W'(td_reg);
        end
    end

    assign sim_inc = EFF_W'(sim_slot_reg) + EFF_W'(1);
    assign outside = pos_y[Y_IN_W-1] || ($unsigned(pos_y) >= HEIGHT_L);
    assign match   = (mem_rdata == {x_reg, y_reg, z_reg});
    assign rd_y9   = 9'(mem_rdata[Z_W +: YW]);

    // Read one stored cell per cycle while scanning or draining
    assign mem_re    = ((state_reg == S_SCAN) || (state_reg == S_DRAIN)) && (cnt_reg < n_reg);
    assign mem_raddr = {slot_reg, cnt_reg[IW-1:0]};

    // Append always lands at the current fill of the add slot
    assign mem_waddr = {slot_reg, n_reg[IW-1:0]};
    assign mem_wdata = {x_reg, y_reg, z_reg};

    assign fill_rd_slot = (operation == OP_DRAIN) ? sim_slot_reg : add_slot_reg;

    always_comb
    begin
        state_next    = state_reg;
        td_next       = td_reg;
        add_slot_next = add_slot_reg;
        sim_slot_next = sim_slot_reg;
        total_next    = total_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        cnt_next      = mem_re ? cnt_reg + FW'(1) : cnt_reg;
        rvld_next     = mem_re;
        rlast_next    = (cnt_reg == n_reg - FW'(1));
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;

        done_next   = 1'b0;
        ox_next     = '0;
        oy_next     = '0;
        oz_next     = '0;
        cv_next     = 1'b0;
        last_next   = 1'b1;
        status_next = ST_OK;

        mem_we       = 1'b0;
        fill_we      = 1'b0;
        fill_wr_slot = slot_reg;
        fill_wr      = '0;

        if (cfg_we)
        begin
            td_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next = rel_x;
                    y_next = pos_y[YW-1:0];
                    z_next = rel_z;
                    n_next = fill_rd;
                    cnt_next = '0;
                    slot_next = fill_rd_slot;
                    case (operation)
                        OP_ADD:
                        begin
                            if (outside)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OUTSIDE;
                            end
                            else if (!is_fluid)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FLUID;
                            end
                            else if (fill_rd == '0)
                            begin
                                state_next = S_APPEND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_TICK:
                        begin
                            add_slot_next = sim_slot_reg;
                            sim_slot_next = (sim_inc >= eff_delay) ? '0 : sim_inc[SW-1:0];
                            done_next     = 1'b1;
                        end
                        OP_DRAIN:
                        begin
                            // Take the cells off the total now; results carry it
                            total_next   = (total_reg >= TW'(fill_rd)) ?
                                           total_reg - TW'(fill_rd) : '0;
                            fill_we      = 1'b1;
                            fill_wr_slot = sim_slot_reg;
                            fill_wr      = '0;
                            if (fill_rd == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rvld_reg && match)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DUPLICATE;
                    state_next  = S_IDLE;
                end
                else if (rvld_reg && rlast_reg)
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (n_reg >= CAP_L)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we       = 1'b1;
                    fill_we      = 1'b1;
                    fill_wr_slot = slot_reg;
                    fill_wr      = n_reg + FW'(1);
                    total_next   = total_reg + TW'(1);
                end
            end

            S_DRAIN:
            begin
                if (rvld_reg)
                begin
                    done_next = 1'b1;
                    cv_next   = 1'b1;
                    ox_next   = mem_rdata[Z_W + YW +: X_W];
                    oy_next   = rd_y9[OUT_Y_W-1:0];
                    oz_next   = mem_rdata[Z_W-1:0];
                    last_next = rlast_reg;
                    if (rlast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            td_reg       <= TD_W'(TD_RESET);
            add_slot_reg <= ADD_SLOT_RST;
            sim_slot_reg <= '0;
            total_reg    <= '0;
            slot_reg     <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            rvld_reg     <= 1'b0;
            rlast_reg    <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            done_reg     <= 1'b0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            oz_reg       <= '0;
            cv_reg       <= 1'b0;
            last_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            td_reg       <= td_next;
            add_slot_reg <= add_slot_next;
            sim_slot_reg <= sim_slot_next;
            total_reg    <= total_next;
            slot_reg     <= slot_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            rvld_reg     <= rvld_next;
            rlast_reg    <= rlast_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            z_reg        <= z_next;
            done_reg     <= done_next;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            oz_reg       <= oz_next;
            cv_reg       <= cv_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
        end
    end

    assign total32 = 32'(total_reg);

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign coord_valid  = cv_reg;
    assign last         = last_reg;
    assign status       = status_reg;
    assign total_queued = total32[TOTAL_W-1:0];

endmodule

@@ tb/dswd_wheel_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the delay slot wheel: keeps its own copy of the wheel,
// works out the results of every accepted request and compares them field by field.
// Depends on dswd_pkg only.
module dswd_wheel_checker #(
    parameter int MAX_SLOTS     = dswd_pkg::DEF_MAX_SLOTS,
    parameter int SLOT_CAPACITY = dswd_pkg::DEF_SLOT_CAPACITY,
    parameter int WORLD_HEIGHT  = dswd_pkg::DEF_WORLD_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [dswd_pkg::OP_W-1:0]           operation,
    input  logic [dswd_pkg::X_W-1:0]            rel_x,
    input  logic signed [dswd_pkg::Y_IN_W-1:0]  pos_y,
    input  logic [dswd_pkg::Z_W-1:0]            rel_z,
    input  logic                                is_fluid,
    input  logic                                cfg_we,
    input  logic [dswd_pkg::TD_W-1:0]           cfg_data,
    input  logic                                done,
    input  logic [dswd_pkg::X_W-1:0]            out_x,
    input  logic [dswd_pkg::OUT_Y_W-1:0]        out_y,
    input  logic [dswd_pkg::Z_W-1:0]            out_z,
    input  logic                                coord_valid,
    input  logic                                last,
    input  logic [dswd_pkg::STATUS_W-1:0]       status,
    input  logic [dswd_pkg::TOTAL_W-1:0]        total_queued,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int TDW = dswd_pkg::TD_W;

    typedef struct packed {
        logic [dswd_pkg::X_W-1:0]     x;
        logic [dswd_pkg::OUT_Y_W-1:0] y;
        logic [dswd_pkg::Z_W-1:0]     z;
    } cell_t;

    typedef struct {
        logic [dswd_pkg::X_W-1:0]      x;
        logic [dswd_pkg::OUT_Y_W-1:0]  y;
        logic [dswd_pkg::Z_W-1:0]      z;
        logic                          valid;
        logic                          fin;
        logic [dswd_pkg::STATUS_W-1:0] code;
        logic [dswd_pkg::TOTAL_W-1:0]  total;
    } wheel_result_t;

    cell_t                  slot_cells [MAX_SLOTS][SLOT_CAPACITY];
    int                     slot_count [MAX_SLOTS];
    int                     add_ptr;
    int                     sim_ptr;
    int                     cell_total;
    logic [dswd_pkg::TD_W-1:0] delay_reg;
    wheel_result_t          owed_results [$];

    // Zero acts as one slot, anything above the wheel size as the full wheel
    function automatic int wheel_span(input logic [dswd_pkg::TD_W-1:0] delay);
        if (delay == 0)
        begin
            return 1;
        end
        if (int'(delay) > MAX_SLOTS)
        begin
            return MAX_SLOTS;
        end
        return int'(delay);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic owe_result(input cell_t c, input logic valid, input logic fin,
                              input logic [dswd_pkg::STATUS_W-1:0] code);
        wheel_result_t r;
        r.x     = c.x;
        r.y     = c.y;
        r.z     = c.z;
        r.valid = valid;
        r.fin   = fin;
        r.code  = code;
        r.total = cell_total[dswd_pkg::TOTAL_W-1:0];
        owed_results.insert(owed_results.size(), r);
    endtask

    // Apply one request to the mirrored wheel and queue its results
    task automatic wheel_step(input logic [dswd_pkg::OP_W-1:0] op,
                              input logic [dswd_pkg::X_W-1:0] x,
                              input logic signed [dswd_pkg::Y_IN_W-1:0] y,
                              input logic [dswd_pkg::Z_W-1:0] z,
                              input logic fluid);
        int    slot;
        int    n;
        int    yv;
        bit    dup;
        cell_t c;
        cell_t blank;
        blank = '0;
        yv    = y;
        case (op)
            dswd_pkg::OP_ADD:
            begin
                slot = add_ptr;
                n    = slot_count[slot];
                c.x  = x;
                c.y  = yv[dswd_pkg::OUT_Y_W-1:0];
                c.z  = z;
                dup  = 1'b0;
                if (yv < 0 || yv >= WORLD_HEIGHT)
                begin
                    owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_OUTSIDE);
                end
                else if (!fluid)
                begin
                    owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_NOT_FLUID);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (slot_cells[slot][i] == c)
                        begin
                            dup = 1'b1;
                        end
                    end
                    if (dup)
                    begin
                        owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_DUPLICATE);
                    end
                    else if (n >= SLOT_CAPACITY)
                    begin
                        owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_FULL);
                    end
                    else
                    begin
                        slot_cells[slot][n] = c;
                        slot_count[slot]    = n + 1;
                        cell_total++;
                        owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_OK);
                    end
                end
            end
            dswd_pkg::OP_TICK:
            begin
                add_ptr = sim_ptr;
                sim_ptr++;
                if (sim_ptr >= wheel_span(delay_reg))
                begin
                    sim_ptr = 0;
                end
                owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_OK);
            end
            dswd_pkg::OP_DRAIN:
            begin
                slot = sim_ptr;
                n    = slot_count[slot];
                cell_total       = (cell_total >= n) ? cell_total - n : 0;
                slot_count[slot] = 0;
                if (n == 0)
                begin
                    owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_OK);
                end
                for (int i = 0; i < n; i++)
                begin
                    owe_result(slot_cells[slot][i], 1'b1, (i == n - 1), dswd_pkg::ST_OK);
                end
            end
            default:
            begin
                owe_result(blank, 1'b0, 1'b1, dswd_pkg::ST_OK);
            end
        endcase
    endtask

    task automatic check_result();
        wheel_result_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch("result with no request owed", 1, 0);
            return;
        end
        want = owed_results.pop_front();
        if (out_x !== want.x)
        begin
            report_mismatch("out_x", int'(out_x), int'(want.x));
        end
        if (out_y !== want.y)
        begin
            report_mismatch("out_y", int'(out_y), int'(want.y));
        end
        if (out_z !== want.z)
        begin
            report_mismatch("out_z", int'(out_z), int'(want.z));
        end
        if (coord_valid !== want.valid)
        begin
            report_mismatch("coord_valid", int'(coord_valid), int'(want.valid));
        end
        if (last !== want.fin)
        begin
            report_mismatch("last", int'(last), int'(want.fin));
        end
        if (status !== want.code)
        begin
            report_mismatch("status", int'(status), int'(want.code));
        end
        if (total_queued !== want.total)
        begin
            report_mismatch("total_queued", int'(total_queued), int'(want.total));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_results.delete();
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                slot_count[s] = 0;
            end
            delay_reg  = TDW'(dswd_pkg::TD_RESET);
            add_ptr    = wheel_span(delay_reg) - 1;
            sim_ptr    = 0;
            cell_total = 0;
            mismatches = 0;
        end
        else
        begin
            // Results always trail their request, so compare before queuing new ones
            if (done)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                delay_reg = cfg_data;
            end
            if (start && !busy)
            begin
                wheel_step(operation, rel_x, pos_y, rel_z, is_fluid);
            end
        end
        pending = owed_results.size();
    end

endmodule

@@ tb/tb_delay_slot_wheel_dedup_top.sv @@
`timescale 1ns / 1ps
// Top of the delay slot wheel testbench: clock, reset, request and delay-register
// stimulus, and the verdict. Depends on dswd_pkg, delay_slot_wheel_dedup_top and
// dswd_wheel_checker.
module tb_delay_slot_wheel_dedup_top;

    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         PHASE_REQUESTS = 37;
    localparam int         FILL_REQUESTS  = 70;
    // The block answers code 3 with a plain empty result
    localparam logic [1:0] OP_SPARE       = 2'd3;

    // Field widths for sizing random values
    localparam int OPW = dswd_pkg::OP_W;
    localparam int XW  = dswd_pkg::X_W;
    localparam int YIW = dswd_pkg::Y_IN_W;
    localparam int ZW  = dswd_pkg::Z_W;
    localparam int OYW = dswd_pkg::OUT_Y_W;
    localparam int TDW = dswd_pkg::TD_W;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [dswd_pkg::OP_W-1:0]           operation = '0;
    logic [dswd_pkg::X_W-1:0]            rel_x = '0;
    logic signed [dswd_pkg::Y_IN_W-1:0]  pos_y = '0;
    logic [dswd_pkg::Z_W-1:0]            rel_z = '0;
    logic                                is_fluid = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [dswd_pkg::TD_W-1:0]           cfg_data = '0;
    logic                                done;
    logic [dswd_pkg::X_W-1:0]            out_x;
    logic [dswd_pkg::OUT_Y_W-1:0]        out_y;
    logic [dswd_pkg::Z_W-1:0]            out_z;
    logic                                coord_valid;
    logic                                last;
    logic [dswd_pkg::STATUS_W-1:0]       status;
    logic [dswd_pkg::TOTAL_W-1:0]        total_queued;

    int mismatch_count;
    int owed_count;
    int cycle_count = 0;
    int burst_left  = 0;

    // Small coordinate pool so that random adds hit duplicates now and then
    logic [dswd_pkg::X_W-1:0]     pool_x [8];
    logic [dswd_pkg::OUT_Y_W-1:0] pool_y [8];
    logic [dswd_pkg::Z_W-1:0]     pool_z [8];

    always #4 clk = ~clk;

    delay_slot_wheel_dedup_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .rel_x        (rel_x),
        .pos_y        (pos_y),
        .rel_z        (rel_z),
        .is_fluid     (is_fluid),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .coord_valid  (coord_valid),
        .last         (last),
        .status       (status),
        .total_queued (total_queued)
    );

    dswd_wheel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .rel_x        (rel_x),
        .pos_y        (pos_y),
        .rel_z        (rel_z),
        .is_fluid     (is_fluid),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .coord_valid  (coord_valid),
        .last         (last),
        .status       (status),
        .total_queued (total_queued),
        .mismatches   (mismatch_count),
        .pending      (owed_count)
    );

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Call at a falling edge. Hold the request until an edge sees busy low, then
    // return at the next falling edge with start still high, so a back-to-back
    // request never lowers and raises start in one step.
    task automatic send_request(input logic [dswd_pkg::OP_W-1:0] op,
                                input logic [dswd_pkg::X_W-1:0] x,
                                input logic signed [dswd_pkg::Y_IN_W-1:0] y,
                                input logic [dswd_pkg::Z_W-1:0] z,
                                input logic fluid);
        start     <= 1'b1;
        operation <= op;
        rel_x     <= x;
        pos_y     <= y;
        rel_z     <= z;
        is_fluid  <= fluid;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    // Drop start for a number of cycles; zero leaves the burst running
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Advance the burst pattern: random-length bursts, random gaps, some gapless
    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 7));
            end
        end
    endtask

    // Drop start and wait until every owed result has come back and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (owed_count != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Write the delay register; only called right after settle
    task automatic write_delay(input logic [dswd_pkg::TD_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= TDW'($urandom);
        @(negedge clk);
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < 8; i++)
        begin
            pool_x[i] = XW'($urandom);
            pool_y[i] = OYW'($urandom);
            pool_z[i] = ZW'($urandom);
        end
    endtask

    // Mostly well-formed adds with ticks and drains, the rest raw noise
    task automatic random_request();
        logic [dswd_pkg::OP_W-1:0]          op;
        logic [dswd_pkg::X_W-1:0]           x;
        logic signed [dswd_pkg::Y_IN_W-1:0] y;
        logic [dswd_pkg::Z_W-1:0]           z;
        logic                               fluid;
        int                                 pick;
        int                                 k;
        pick  = $urandom_range(0, 99);
        x     = XW'($urandom);
        y     = YIW'($urandom);
        z     = ZW'($urandom);
        fluid = 1'($urandom);
        op    = OPW'($urandom);
        if (pick < 55)
        begin
            op    = dswd_pkg::OP_ADD;
            fluid = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, 7);
                x = pool_x[k];
                y = YIW'(pool_y[k]);
                z = pool_z[k];
            end
            else
            begin
                y = YIW'($urandom_range(0, 255));
            end
        end
        else if (pick < 70)
        begin
            op = dswd_pkg::OP_TICK;
        end
        else if (pick < 82)
        begin
            op = dswd_pkg::OP_DRAIN;
        end
        send_request(op, x, y, z, fluid);
        pace();
    endtask

    // Push one slot past capacity, then tick and drain all the way round the wheel
    task automatic overfill_slot();
        logic [dswd_pkg::OUT_Y_W-1:0] base_y;
        base_y = OYW'($urandom_range(0, 200));
        for (int i = 0; i < FILL_REQUESTS; i++)
        begin
            send_request(dswd_pkg::OP_ADD, XW'(i % 16), YIW'(int'(base_y) + i / 16),
                         ZW'($urandom), 1'b1);
            pace();
        end
        for (int i = 0; i < 16; i++)
        begin
            send_request(dswd_pkg::OP_TICK, XW'($urandom), YIW'($urandom),
                         ZW'($urandom), 1'($urandom));
            send_request(dswd_pkg::OP_DRAIN, XW'($urandom), YIW'($urandom),
                         ZW'($urandom), 1'($urandom));
            pace();
        end
    endtask

    initial
    begin
        logic [dswd_pkg::TD_W-1:0] phase_delays [7];
        phase_delays = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd0};
        phase_delays[6] = TDW'($urandom);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pass at the reset delay of five slots: empty drain, height
        // extremes on both sides of the world, not fluid, the coordinate
        // extremes, a duplicate, the spare code, then tick round to the add
        // slot and drain it twice.
        send_request(dswd_pkg::OP_DRAIN, 4'd0, 10'sd0, 4'd0, 1'b0);
        send_request(dswd_pkg::OP_ADD, 4'd15, -10'sd512, 4'd15, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd15, 10'sd511, 4'd15, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd0, 10'sd256, 4'd0, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd0, -10'sd1, 4'd0, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd3, 10'sd0, 4'd3, 1'b0);
        send_request(dswd_pkg::OP_ADD, 4'd0, 10'sd0, 4'd0, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd15, 10'sd255, 4'd15, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd15, 10'sd255, 4'd15, 1'b1);
        send_request(dswd_pkg::OP_ADD, 4'd0, 10'sd0, 4'd0, 1'b1);
        send_request(OP_SPARE, 4'd15, -10'sd1, 4'd15, 1'b1);
        idle_cycles(3);
        repeat (4)
        begin
            send_request(dswd_pkg::OP_TICK, 4'd15, 10'sd511, 4'd15, 1'b1);
        end
        send_request(dswd_pkg::OP_DRAIN, 4'd0, 10'sd0, 4'd0, 1'b1);
        send_request(dswd_pkg::OP_DRAIN, 4'd15, -10'sd512, 4'd15, 1'b0);
        send_request(dswd_pkg::OP_TICK, 4'd0, 10'sd0, 4'd0, 1'b0);
        send_request(dswd_pkg::OP_ADD, 4'd7, 10'sd128, 4'd8, 1'b1);

        // Random phases, each under its own delay setting; the wide wheel phase
        // also overfills a slot to reach the full-slot reject and a 64-cell drain
        for (int p = 0; p < 7; p++)
        begin
            settle();
            write_delay(phase_delays[p]);
            refresh_pool();
            if (p == 0)
            begin
                overfill_slot();
            end
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                random_request();
            end
        end

        settle();
        repeat (16) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
